FILE: hdl/pfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared types and constants of the pixel format packer.
// ----------------------------------------------------------------------------
package pfp_pkg;

  // Chunk size in bytes; a 16-bit chunk holds half as many elements
  localparam int unsigned CHUNK_BYTES = 256;
  localparam int unsigned LIMIT_W     = 9;
  localparam logic [LIMIT_W-1:0] CHUNK_LIMIT_WIDE =
    LIMIT_W'((CHUNK_BYTES / 2 == 0) ? 1 : CHUNK_BYTES / 2);
  localparam logic [LIMIT_W-1:0] CHUNK_LIMIT_BYTE = LIMIT_W'(CHUNK_BYTES);

  // Configuration register indexes
  localparam logic [1:0] REG_PIXEL_FORMAT   = 2'd0;
  localparam logic [1:0] REG_BIG_ENDIAN_OUT = 2'd1;
  localparam logic [1:0] REG_MONO_THRESHOLD = 2'd2;

  localparam logic [7:0] MONO_THRESHOLD_RST = 8'd127;

  typedef enum logic [1:0] {
    FMT_RGB565 = 2'd0,
    FMT_BGR565 = 2'd1,
    FMT_BGR332 = 2'd2,
    FMT_MONO   = 2'd3
  } fmt_e;

  typedef struct packed {
    fmt_e       pixel_format;
    logic       big_endian_out;
    logic [7:0] mono_threshold;
  } cfg_t;

  typedef struct packed {
    logic [2:0] mono_bit_count;
    logic [7:0] mono_pack_byte;
    logic [7:0] chunk_elem_count;
  } pack_state_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [1:0] byte_count;
    logic       chunk_end;
  } word_t;

endpackage
`default_nettype wire

FILE: hdl/pfp_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfp_cfg_regs
// Configuration registers, written through a plain index/data port.
// ----------------------------------------------------------------------------
module pfp_cfg_regs
  import pfp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i,
  output cfg_t            cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Decode the write onto the addressed register
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PIXEL_FORMAT:   cfg_d.pixel_format   = fmt_e'(cfg_wdata_i[1:0]);
        REG_BIG_ENDIAN_OUT: cfg_d.big_endian_out = cfg_wdata_i[0];
        REG_MONO_THRESHOLD: cfg_d.mono_threshold = cfg_wdata_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_format   <= FMT_RGB565;
      cfg_q.big_endian_out <= 1'b0;
      cfg_q.mono_threshold <= MONO_THRESHOLD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

FILE: hdl/pfp_convert.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfp_convert
// Converts one registered pixel to an output word and the next packer state.
// ----------------------------------------------------------------------------
module pfp_convert
  import pfp_pkg::*;
(
  input  pixel_t      pix_i,
  input  cfg_t        cfg_i,
  input  pack_state_t state_i,
  output word_t       word_o,
  output logic        emit_o,
  output pack_state_t state_o
);

  logic [15:0]        rgb_word;
  logic [7:0]         byte_val;
  logic [9:0]         grey_sum;
  logic [9:0]         grey_limit;
  logic               mono_bit;
  logic [7:0]         mono_packed;
  logic               mono_emit;
  logic               is_wide;
  logic [LIMIT_W-1:0] chunk_limit;
  logic [LIMIT_W-1:0] chunk_next;
  logic               chunk_close;

  // Build the 16-bit words and the 332 byte
  always_comb begin
    if (cfg_i.pixel_format == FMT_RGB565) begin
      rgb_word = {pix_i.blue[7:3], pix_i.green[7:2], pix_i.red[7:3]};
    end else begin
      rgb_word = {pix_i.red[7:3], pix_i.green[7:2], pix_i.blue[7:3]};
    end
    byte_val = {pix_i.blue[7:6], pix_i.green[7:5], pix_i.red[7:5]};
  end

  // Mean above threshold: sum / 3 > t is the same as sum >= 3t + 3
  assign grey_sum    = 10'(pix_i.red) + 10'(pix_i.green) + 10'(pix_i.blue);
  assign grey_limit  = 10'(cfg_i.mono_threshold) * 10'd3 + 10'd3;
  assign mono_bit    = (grey_sum >= grey_limit);
  assign mono_packed = state_i.mono_pack_byte
                     | (8'(mono_bit) << (3'd7 - state_i.mono_bit_count));
  assign mono_emit   = (state_i.mono_bit_count == 3'd7) || pix_i.last_pixel;

  // Chunk accounting
  assign is_wide     = (cfg_i.pixel_format == FMT_RGB565)
                    || (cfg_i.pixel_format == FMT_BGR565);
  assign chunk_limit = is_wide ? CHUNK_LIMIT_WIDE : CHUNK_LIMIT_BYTE;
  assign chunk_next  = LIMIT_W'(state_i.chunk_elem_count) + LIMIT_W'(1);
  assign chunk_close = (chunk_next >= chunk_limit) || pix_i.last_pixel;

  // Select the element and the next state
  always_comb begin
    word_o  = '0;
    emit_o  = 1'b1;
    state_o = state_i;
    case (cfg_i.pixel_format)
      FMT_RGB565, FMT_BGR565: begin
        word_o.first_byte  = cfg_i.big_endian_out ? rgb_word[15:8] : rgb_word[7:0];
        word_o.second_byte = cfg_i.big_endian_out ? rgb_word[7:0] : rgb_word[15:8];
        word_o.byte_count  = 2'd2;
      end
      FMT_BGR332: begin
        word_o.first_byte = byte_val;
        word_o.byte_count = 2'd1;
      end
      FMT_MONO: begin
        word_o.first_byte = mono_packed;
        word_o.byte_count = 2'd1;
        emit_o            = mono_emit;
        if (mono_emit) begin
          state_o.mono_bit_count = 3'd0;
          state_o.mono_pack_byte = 8'd0;
        end else begin
          state_o.mono_bit_count = state_i.mono_bit_count + 3'd1;
          state_o.mono_pack_byte = mono_packed;
        end
      end
      default: emit_o = 1'b0;
    endcase
    word_o.chunk_end = chunk_close;
    if (emit_o) begin
      state_o.chunk_elem_count = chunk_close ? 8'd0 : chunk_next[7:0];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/pixel_format_packer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_format_packer_top
// Converts RGB888 pixels to RGB565, BGR565, BGR332 or packed 1-bit mono.
// ----------------------------------------------------------------------------
// The packer takes one pixel word per clock and passes it through a pixel
// register, the conversion logic, and an output register. Throughput is one
// pixel per cycle, set by the single conversion stage; a stall on the output
// holds the output and pixel registers, and the input stalls only once both
// are full. Mono pixels yield one byte per eight pixels (or at the last
// pixel), so most produce no output word. Configuration is to be written
// by the user only while the packer is idle; nothing enforces this.
// ----------------------------------------------------------------------------
module pixel_format_packer_top
  import pfp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] red_i,
  input  wire logic [7:0] green_i,
  input  wire logic [7:0] blue_i,
  input  wire logic       last_pixel_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      first_byte_o,
  output logic [7:0]      second_byte_o,
  output logic [1:0]      byte_count_o,
  output logic            chunk_end_o
);

  cfg_t        cfg;
  pixel_t      pix_q;
  logic        pix_valid_q;
  pack_state_t state_q;
  pack_state_t state_d;
  word_t       word_d;
  word_t       word_q;
  logic        emit;
  logic        out_valid_q;
  logic        out_free;
  logic        advance;
  logic        in_accept;

  pfp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  pfp_convert u_conv (
    .pix_i  (pix_q),
    .cfg_i  (cfg),
    .state_i(state_q),
    .word_o (word_d),
    .emit_o (emit),
    .state_o(state_d)
  );

  // Handshake: move the pixel on when the output register can take it
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = pix_valid_q && out_free;
  assign in_stall_o = pix_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Pixel register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q <= 1'b0;
    end else if (in_accept) begin
      pix_valid_q <= 1'b1;
    end else if (advance) begin
      pix_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pix_q <= '{red: red_i, green: green_i, blue: blue_i, last_pixel: last_pixel_i};
    end
  end

  // Packer state: advance with each converted pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign first_byte_o  = word_q.first_byte;
  assign second_byte_o = word_q.second_byte;
  assign byte_count_o  = word_q.byte_count;
  assign chunk_end_o   = word_q.chunk_end;

endmodule
`default_nettype wire

FILE: hdl/pfp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfp_checker
// Port-level checks of the pixel format packer, bound to the top level.
// ----------------------------------------------------------------------------
module pfp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [7:0] red_i,
  input wire logic [7:0] green_i,
  input wire logic [7:0] blue_i,
  input wire logic       last_pixel_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] first_byte_o,
  input wire logic [7:0] second_byte_o,
  input wire logic [1:0] byte_count_o,
  input wire logic       chunk_end_o
);

  // No word is offered while reset is held
  a_no_valid_in_reset: assert property (
    @(posedge clk_i) !rst_ni |-> !out_valid_o
  ) else $error("output word valid during reset");

  // A stalled input word holds
  a_in_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(red_i) && $stable(green_i)
      && $stable(blue_i) && $stable(last_pixel_i)
  ) else $error("stalled input word changed");

  // A stalled word holds
  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(first_byte_o)
      && $stable(second_byte_o) && $stable(byte_count_o) && $stable(chunk_end_o)
  ) else $error("stalled output word changed");

  // Every word carries one or two bytes
  a_byte_count: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (byte_count_o == 2'd1) || (byte_count_o == 2'd2)
  ) else $error("illegal byte count");

  // Single-byte words leave the second byte clear
  a_second_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (byte_count_o == 2'd1) |-> (second_byte_o == 8'd0)
  ) else $error("second byte set on single-byte word");

endmodule

bind pixel_format_packer_top pfp_checker u_pfp_checker (.*);
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the pixel format packer against a cycle-free predictor of its output
// words, driving pixels and output stalls with random gaps in all formats.
// ----------------------------------------------------------------------------
module tb;
  import pfp_pkg::*;

  // Cycles to let pass after the last word so the two-stage pipeline is empty
  localparam int unsigned DRAIN_CYCLES  = 4;
  localparam int unsigned RANDOM_PIXELS = 150;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       cfg_we      = 1'b0;
  logic [1:0] cfg_idx     = REG_PIXEL_FORMAT;
  logic [7:0] cfg_wdata   = '0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic [7:0] red         = '0;
  logic [7:0] green       = '0;
  logic [7:0] blue        = '0;
  logic       last_pixel  = 1'b0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [1:0] byte_count;
  logic       chunk_end;

  // Predictor copy of the configuration and the packing state
  fmt_e       pred_fmt        = FMT_RGB565;
  logic       pred_msb_first  = 1'b0;
  logic [7:0] pred_threshold  = MONO_THRESHOLD_RST;
  logic [2:0] mono_bits       = '0;
  logic [7:0] mono_acc        = '0;
  logic [7:0] chunk_cnt       = '0;

  word_t       expected_words[$];
  bit          in_gaps_on    = 1'b1;
  bit          out_stalls_on = 1'b1;
  int unsigned stall_left    = 0;
  int unsigned fail_count    = 0;
  int unsigned pixels_sent   = 0;
  int unsigned words_checked = 0;
  int unsigned mono_words    = 0;

  pixel_format_packer_top u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .red_i        (red),
    .green_i      (green),
    .blue_i       (blue),
    .last_pixel_i (last_pixel),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .first_byte_o (first_byte),
    .second_byte_o(second_byte),
    .byte_count_o (byte_count),
    .chunk_end_o  (chunk_end)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Advance the chunk counter; flag the element that closes a chunk or image
  function automatic logic chunk_advance(input logic [LIMIT_W-1:0] limit,
                                         input logic is_last);
    logic [LIMIT_W-1:0] next_cnt;
    next_cnt = LIMIT_W'(chunk_cnt) + LIMIT_W'(1);
    if (next_cnt >= limit || is_last) begin
      chunk_cnt = '0;
      return 1'b1;
    end
    chunk_cnt = next_cnt[7:0];
    return 1'b0;
  endfunction

  // Convert one accepted pixel and queue the word it yields, if any
  function automatic void predict_pixel(input pixel_t px);
    word_t      w;
    logic [15:0] wide;
    logic [9:0] sum;
    logic [9:0] grey;
    logic       mono_on;
    logic [7:0] mono_next;
    w = '0;
    case (pred_fmt)
      FMT_RGB565, FMT_BGR565: begin
        if (pred_fmt == FMT_RGB565) begin
          wide = {px.blue[7:3], px.green[7:2], px.red[7:3]};
        end else begin
          wide = {px.red[7:3], px.green[7:2], px.blue[7:3]};
        end
        w.first_byte  = pred_msb_first ? wide[15:8] : wide[7:0];
        w.second_byte = pred_msb_first ? wide[7:0] : wide[15:8];
        w.byte_count  = 2'd2;
        w.chunk_end   = chunk_advance(CHUNK_LIMIT_WIDE, px.last_pixel);
        expected_words = {expected_words, w};
      end
      FMT_BGR332: begin
        w.first_byte = {px.blue[7:6], px.green[7:5], px.red[7:5]};
        w.byte_count = 2'd1;
        w.chunk_end  = chunk_advance(CHUNK_LIMIT_BYTE, px.last_pixel);
        expected_words = {expected_words, w};
      end
      default: begin
        sum       = 10'(px.red) + 10'(px.green) + 10'(px.blue);
        grey      = sum / 10'd3;
        mono_on   = grey > 10'(pred_threshold);
        mono_next = mono_acc | (8'(mono_on) << (3'd7 - mono_bits));
        // Emit on a full byte or at the end of the image
        if (mono_bits == 3'd7 || px.last_pixel) begin
          mono_bits    = '0;
          mono_acc     = '0;
          w.first_byte = mono_next;
          w.byte_count = 2'd1;
          w.chunk_end  = chunk_advance(CHUNK_LIMIT_BYTE, px.last_pixel);
          expected_words = {expected_words, w};
          mono_words++;
        end else begin
          mono_bits = mono_bits + 3'd1;
          mono_acc  = mono_next;
        end
      end
    endcase
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Check each accepted word against the oldest expectation; draw output stalls
  always @(posedge clk or negedge rst_n) begin
    word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: first_byte %0d second_byte %0d byte_count %0d",
                 first_byte, second_byte, byte_count);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          compare_field("first_byte", 32'(want.first_byte), 32'(first_byte));
          compare_field("second_byte", 32'(want.second_byte), 32'(second_byte));
          compare_field("byte_count", 32'(want.byte_count), 32'(byte_count));
          compare_field("chunk_end", 32'(want.chunk_end), 32'(chunk_end));
          words_checked++;
        end
        stall_left = out_stalls_on ? $urandom_range(0, 4) : 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Write all three registers on consecutive cycles; call only when idle
  task automatic set_config(input fmt_e fmt, input logic msb_first,
                            input logic [7:0] threshold);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_PIXEL_FORMAT;
    cfg_wdata <= 8'(fmt);
    @(posedge clk);
    cfg_idx   <= REG_BIG_ENDIAN_OUT;
    cfg_wdata <= {7'b0, msb_first};
    @(posedge clk);
    cfg_idx   <= REG_MONO_THRESHOLD;
    cfg_wdata <= threshold;
    @(posedge clk);
    cfg_we <= 1'b0;
    pred_fmt        = fmt;
    pred_msb_first  = msb_first;
    pred_threshold  = threshold;
  endtask

  // Drive one pixel after a random gap and hold it until accepted
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic is_last);
    int unsigned gap;
    pixel_t      px;
    gap = in_gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    red        <= r;
    green      <= g;
    blue       <= b;
    last_pixel <= is_last;
    px = {r, g, b, is_last};
    do @(posedge clk); while (in_stall);
    predict_pixel(px);
    pixels_sent++;
  endtask

  // Drop valid and wait until every expected word is out and the pipe is empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Reset values: little-endian RGB565
  task automatic test_reset_defaults();
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hF8, 8'h04, 8'h07, 1'b1);
    wait_idle();
  endtask

  // Both 16-bit formats big-endian, and BGR565 also little-endian
  task automatic test_wide_formats();
    set_config(FMT_BGR565, 1'b1, 8'd127);
    send_pixel(8'hF8, 8'hFC, 8'h00, 1'b0);
    send_pixel(8'h07, 8'h03, 8'hF8, 1'b0);
    send_pixel(8'h5A, 8'hA5, 8'h3C, 1'b1);
    wait_idle();
    set_config(FMT_RGB565, 1'b1, 8'd127);
    send_pixel(8'hF8, 8'h04, 8'h07, 1'b1);
    wait_idle();
    set_config(FMT_BGR565, 1'b0, 8'd127);
    send_pixel(8'hF8, 8'h04, 8'h07, 1'b1);
    wait_idle();
  endtask

  task automatic test_byte_format();
    set_config(FMT_BGR332, 1'b0, 8'd127);
    send_pixel(8'hE0, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'hE0, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'hC0, 1'b1);
    wait_idle();
  endtask

  // Full mono byte, partial flush at the last pixel, threshold extremes
  task automatic test_mono_packing();
    set_config(FMT_MONO, 1'b0, 8'd254);
    for (int i = 0; i < 8; i++) begin
      send_pixel((i % 2) ? 8'h00 : 8'hFF, (i % 2) ? 8'h00 : 8'hFF,
                 (i % 2) ? 8'h00 : 8'hFF, 1'b0);
    end
    wait_idle();
    set_config(FMT_MONO, 1'b0, 8'd0);
    send_pixel(8'd1, 8'd1, 8'd1, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd2, 1'b0);
    send_pixel(8'd0, 8'd1, 8'd2, 1'b1);
    wait_idle();
    set_config(FMT_MONO, 1'b0, 8'd255);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    wait_idle();
  endtask

  // Keep a partial mono byte across a detour through another format
  task automatic test_format_switch();
    set_config(FMT_MONO, 1'b0, 8'd127);
    repeat (3) send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    wait_idle();
    set_config(FMT_BGR332, 1'b0, 8'd127);
    send_pixel(8'h20, 8'h40, 8'h80, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
    wait_idle();
    set_config(FMT_MONO, 1'b1, 8'd127);
    repeat (5) send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    wait_idle();
  endtask

  // Wrap a byte chunk, then switch to 16 bits past the smaller chunk size
  task automatic test_chunk_boundaries();
    set_config(FMT_BGR332, 1'b0, 8'd127);
    repeat (390) send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    wait_idle();
    set_config(FMT_RGB565, 1'b0, 8'd127);
    repeat (130) send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
    wait_idle();
  endtask

  // Random images under random settings, some left open across settings
  task automatic test_random_images();
    int unsigned sent;
    int unsigned len;
    logic        closes;
    logic [7:0]  threshold;
    logic [7:0]  grey;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      case ($urandom_range(0, 3))
        0:       threshold = 8'd0;
        1:       threshold = 8'd255;
        default: threshold = 8'($urandom);
      endcase
      set_config(fmt_e'($urandom_range(0, 3)), 1'($urandom), threshold);
      in_gaps_on    = $urandom_range(0, 3) != 0;
      out_stalls_on = $urandom_range(0, 3) != 0;
      len    = $urandom_range(1, 40);
      closes = $urandom_range(0, 4) != 0;
      for (int i = 0; i < len; i++) begin
        // Mix near-grey pixels around the threshold with arbitrary colors
        if ($urandom_range(0, 3) == 0) begin
          grey = threshold ^ 8'($urandom_range(0, 3));
          r = grey;
          g = grey;
          b = grey ^ 8'($urandom_range(0, 1));
        end else begin
          r = 8'($urandom);
          g = 8'($urandom);
          b = 8'($urandom);
        end
        send_pixel(r, g, b, closes && (i == len - 1));
      end
      sent += len;
      wait_idle();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_wide_formats();
    test_byte_format();
    test_mono_packing();
    test_format_switch();
    test_chunk_boundaries();
    test_random_images();
    $display("Sent %0d pixels through all formats, byte orders and threshold extremes;",
             pixels_sent);
    $display("checked %0d words, %0d of them packed mono bytes.", words_checked, mono_words);
    if (fail_count == 0) begin
      $display("pixel_format_packer_top test passed");
    end else begin
      $display("pixel_format_packer_top test failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("pixel_format_packer_top test failed");
    $finish;
  end

endmodule
